// File: hw/rtl/pap_pkg.sv
// ----------------------------------------------------------------------------
// pap_pkg
// Shared widths, command and status types for the polygon area and perimeter
// block.
// ----------------------------------------------------------------------------
package pap_pkg;

   localparam int MAX_VERTICES = 1024;
   localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

   localparam int COORD_W    = 16;
   localparam int DIFF_W     = COORD_W + 1;
   localparam int PROD_W     = 2 * DIFF_W;
   localparam int SQ_W       = 2 * COORD_W;
   localparam int SQSUM_W    = SQ_W + 1;
   localparam int FRAC_SHIFT = 16;
   localparam int ROOT_W     = (SQSUM_W + FRAC_SHIFT + 1) / 2;
   localparam int RAD_W      = 2 * ROOT_W;
   localparam int REM_W      = ROOT_W + 1;
   localparam int STEP_W     = $clog2(ROOT_W);

   localparam int AREA_W     = 46;
   localparam int AREA_OUT_W = 44;
   localparam int PERIM_W    = 36;
   localparam int TOTAL_W    = 11;

   typedef enum logic [1:0] {
      MUL_AREA,
      MUL_DXX,
      MUL_DYY
   } mul_sel_type;

   typedef struct packed {
      logic        capture;
      logic        first_load;
      logic        prev_load;
      logic        count_step;
      logic        edge_load;
      logic        edge_close;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        area_add;
      logic        sq_keep;
      logic        sqrt_start;
      logic        perim_add;
      logic        out_load;
   } pap_cmd_type;

   typedef struct packed {
      logic count_zero;
      logic sqrt_busy;
      logic sqrt_done;
      logic rsp_full;
   } pap_stat_type;

endpackage

// File: hw/rtl/pap_isqrt.sv
// ----------------------------------------------------------------------------
// pap_isqrt
// Bit-serial restoring integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module pap_isqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [pap_pkg::RAD_W-1:0]   radicand,
   output logic                        busy,
   output logic                        done,
   output logic [pap_pkg::ROOT_W-1:0]  root
);
   import pap_pkg::*;

   logic [RAD_W-1:0]  rad_ff, rad_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [REM_W+1:0]  rem_sh;
   logic [REM_W+1:0]  trial;
   logic [REM_W+1:0]  diff;
   logic              ge;
   logic              last_step;

   assign rem_sh    = {rem_ff, rad_ff[RAD_W-1 -: 2]};
   assign trial     = {1'b0, root_ff, 2'b01};
   assign diff      = rem_sh - trial;
   assign ge        = (rem_sh >= trial);
   assign last_step = (step_ff == STEP_W'(ROOT_W - 1));

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in  = {rad_ff[RAD_W-3:0], 2'b00};
         rem_in  = ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
         root_in = {root_ff[ROOT_W-2:0], ge};
         step_in = step_ff + STEP_W'(1);
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign root = root_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("square root started while busy");

endmodule

// File: hw/rtl/pap_datapath.sv
// ----------------------------------------------------------------------------
// pap_datapath
// Vertex registers, shared multiplier, area and perimeter accumulators and
// the result register.
// ----------------------------------------------------------------------------
module pap_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic signed [pap_pkg::COORD_W-1:0]  req_x_coord,
   input  logic signed [pap_pkg::COORD_W-1:0]  req_y_coord,
   input  pap_pkg::pap_cmd_type                cmd,
   output pap_pkg::pap_stat_type               stat,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [pap_pkg::AREA_OUT_W-1:0]      rsp_area_doubled,
   output logic [pap_pkg::PERIM_W-1:0]         rsp_perimeter_q8,
   output logic [pap_pkg::TOTAL_W-1:0]         rsp_vertex_total,
   output logic                                rsp_overflow
);
   import pap_pkg::*;

   logic signed [COORD_W-1:0] cur_x_ff, cur_y_ff;
   logic signed [COORD_W-1:0] first_x_ff, first_y_ff;
   logic signed [COORD_W-1:0] prev_x_ff, prev_y_ff;
   logic signed [DIFF_W-1:0]  dx_ff, sy_ff, dy_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic [SQ_W-1:0]           dx2_ff;
   logic signed [AREA_W-1:0]  area_ff, area_in;
   logic [PERIM_W-1:0]        perim_ff, perim_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic                      over_ff, over_in;
   logic                      rsp_valid_ff;
   logic [AREA_OUT_W-1:0]     area_out_ff;
   logic [PERIM_W-1:0]        perim_out_ff;
   logic [TOTAL_W-1:0]        total_out_ff;
   logic                      over_out_ff;

   logic signed [COORD_W-1:0] ax, ay, bx, by;
   logic signed [DIFF_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0]  product;
   logic signed [AREA_W:0]    area_sum;
   logic [PERIM_W:0]          perim_sum;
   logic [SQSUM_W-1:0]        sq_sum;
   logic [RAD_W-1:0]          radicand;
   logic [AREA_W-1:0]         area_abs;
   logic [ROOT_W-1:0]         root;
   logic                      sqrt_busy, sqrt_done;

   // edge endpoints a -> b; the closing edge runs last vertex -> first
   assign ax = cmd.edge_close ? cur_x_ff   : prev_x_ff;
   assign ay = cmd.edge_close ? cur_y_ff   : prev_y_ff;
   assign bx = cmd.edge_close ? first_x_ff : cur_x_ff;
   assign by = cmd.edge_close ? first_y_ff : cur_y_ff;

   always_comb begin
      case (cmd.mul_sel)
         MUL_AREA: begin
            mul_a = dx_ff;
            mul_b = sy_ff;
         end
         MUL_DXX: begin
            mul_a = dx_ff;
            mul_b = dx_ff;
         end
         default: begin
            mul_a = dy_ff;
            mul_b = dy_ff;
         end
      endcase
   end

   assign product = PROD_W'(mul_a) * PROD_W'(mul_b);

   assign area_sum = (AREA_W+1)'(area_ff) + (AREA_W+1)'(prod_ff);
   assign sq_sum   = SQSUM_W'(dx2_ff) + SQSUM_W'(prod_ff[SQ_W-1:0]);
   assign radicand = RAD_W'(sq_sum) << FRAC_SHIFT;
   assign perim_sum = (PERIM_W+1)'(perim_ff) + (PERIM_W+1)'(root);
   assign area_abs = area_ff[AREA_W-1] ? AREA_W'(-area_ff) : AREA_W'(area_ff);

   always_comb begin
      area_in  = area_ff;
      perim_in = perim_ff;
      count_in = count_ff;
      over_in  = over_ff;
      if (cmd.area_add) begin
         if (area_sum[AREA_W] != area_sum[AREA_W-1]) begin
            area_in = area_sum[AREA_W] ? {1'b1, {(AREA_W-1){1'b0}}}
                                       : {1'b0, {(AREA_W-1){1'b1}}};
         end else begin
            area_in = area_sum[AREA_W-1:0];
         end
      end
      if (cmd.perim_add) begin
         perim_in = perim_sum[PERIM_W] ? '1 : perim_sum[PERIM_W-1:0];
      end
      if (cmd.count_step) begin
         if (count_ff >= CNT_W'(MAX_VERTICES)) begin
            over_in = 1'b1;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end
      if (cmd.out_load) begin
         area_in  = '0;
         perim_in = '0;
         count_in = '0;
         over_in  = 1'b0;
      end
   end

   pap_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.sqrt_start),
      .radicand (radicand),
      .busy     (sqrt_busy),
      .done     (sqrt_done),
      .root     (root)
   );

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cur_x_ff <= req_x_coord;
         cur_y_ff <= req_y_coord;
      end
      if (cmd.edge_load) begin
         dx_ff <= DIFF_W'(ax) - DIFF_W'(bx);
         sy_ff <= DIFF_W'(by) + DIFF_W'(ay);
         dy_ff <= DIFF_W'(ay) - DIFF_W'(by);
      end
      if (cmd.mul_en) begin
         prod_ff <= product;
      end
      if (cmd.sq_keep) begin
         dx2_ff <= prod_ff[SQ_W-1:0];
      end
      if (cmd.out_load) begin
         area_out_ff  <= (area_abs[AREA_W-1:AREA_OUT_W] != '0) ? '1
                                                               : area_abs[AREA_OUT_W-1:0];
         perim_out_ff <= perim_ff;
         total_out_ff <= TOTAL_W'(count_ff);
         over_out_ff  <= over_ff;
      end
      if (reset) begin
         first_x_ff   <= '0;
         first_y_ff   <= '0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         area_ff      <= '0;
         perim_ff     <= '0;
         count_ff     <= '0;
         over_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.out_load) begin
            first_x_ff <= '0;
            first_y_ff <= '0;
            prev_x_ff  <= '0;
            prev_y_ff  <= '0;
         end else begin
            if (cmd.first_load) begin
               first_x_ff <= cur_x_ff;
               first_y_ff <= cur_y_ff;
            end
            if (cmd.prev_load) begin
               prev_x_ff <= cur_x_ff;
               prev_y_ff <= cur_y_ff;
            end
         end
         area_ff      <= area_in;
         perim_ff     <= perim_in;
         count_ff     <= count_in;
         over_ff      <= over_in;
         rsp_valid_ff <= cmd.out_load | (rsp_valid_ff & rsp_stall);
      end
   end

   assign stat.count_zero = (count_ff == '0);
   assign stat.sqrt_busy  = sqrt_busy;
   assign stat.sqrt_done  = sqrt_done;
   assign stat.rsp_full   = rsp_valid_ff & rsp_stall;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_area_doubled = area_out_ff;
   assign rsp_perimeter_q8 = perim_out_ff;
   assign rsp_vertex_total = total_out_ff;
   assign rsp_overflow     = over_out_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_valid_ff && rsp_stall))
      else $error("result register overwritten while stalled");

   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_VERTICES))
      else $error("vertex count beyond limit");

endmodule

// File: hw/rtl/pap_ctrl.sv
// ----------------------------------------------------------------------------
// pap_ctrl
// Sequencer that walks each edge a vertex adds through edge setup, multiply,
// square root and accumulation, and closes the polygon on its last vertex.
// ----------------------------------------------------------------------------
module pap_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_last_vertex,
   input  pap_pkg::pap_stat_type stat,
   output pap_pkg::pap_cmd_type  cmd
);
   import pap_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_BEGIN,
      S_LOAD,
      S_MUL_AREA,
      S_MUL_DX,
      S_MUL_DY,
      S_SQRT,
      S_WAIT,
      S_OUT
   } state_type;

   state_type state_ff;
   logic      last_ff;
   logic      close_ff;

   always_comb begin
      cmd         = '0;
      cmd.mul_sel = MUL_AREA;
      cmd.edge_close = close_ff;
      unique case (state_ff)
         S_IDLE: begin
            cmd.capture = req_valid;
         end
         S_BEGIN: begin
            cmd.count_step = 1'b1;
            if (stat.count_zero) begin
               cmd.first_load = 1'b1;
               cmd.prev_load  = 1'b1;
            end
         end
         S_LOAD: begin
            cmd.edge_load = 1'b1;
            cmd.prev_load = !close_ff;
         end
         S_MUL_AREA: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_AREA;
         end
         S_MUL_DX: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = MUL_DXX;
            cmd.area_add = 1'b1;
         end
         S_MUL_DY: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_DYY;
            cmd.sq_keep = 1'b1;
         end
         S_SQRT: begin
            cmd.sqrt_start = 1'b1;
         end
         S_WAIT: begin
            cmd.perim_add = stat.sqrt_done;
         end
         S_OUT: begin
            cmd.out_load = !stat.rsp_full;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         last_ff  <= 1'b0;
         close_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  last_ff  <= req_last_vertex;
                  state_ff <= S_BEGIN;
               end
            end
            S_BEGIN: begin
               if (stat.count_zero) begin
                  close_ff <= 1'b1;
                  state_ff <= last_ff ? S_LOAD : S_IDLE;
               end else begin
                  close_ff <= 1'b0;
                  state_ff <= S_LOAD;
               end
            end
            S_LOAD:     state_ff <= S_MUL_AREA;
            S_MUL_AREA: state_ff <= S_MUL_DX;
            S_MUL_DX:   state_ff <= S_MUL_DY;
            S_MUL_DY:   state_ff <= S_SQRT;
            S_SQRT:     state_ff <= S_WAIT;
            S_WAIT: begin
               if (stat.sqrt_done) begin
                  if (close_ff) begin
                     state_ff <= S_OUT;
                  end else if (last_ff) begin
                     close_ff <= 1'b1;
                     state_ff <= S_LOAD;
                  end else begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            S_OUT: begin
               if (!stat.rsp_full) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   a_idle_sqrt_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !stat.sqrt_busy)
      else $error("square root busy while sequencer idle");

endmodule

// File: hw/rtl/polygon_area_perimeter_top.sv
// ----------------------------------------------------------------------------
// polygon_area_perimeter_top
// Shoelace area and floored edge-length perimeter of a polygon fed one
// vertex per transfer.
// ----------------------------------------------------------------------------
// Vertices enter on the req_ channel (valid/stall), one per transfer, with
// req_last_vertex set on the final vertex. The first vertex of a polygon is
// kept; each following vertex adds one edge, and the last one also adds the
// closing edge back to the first vertex. After the last vertex one result
// transfer on the rsp_ channel carries twice the absolute area, the Q.8
// perimeter, the vertex count and the overflow flag; the block then starts
// a fresh polygon.
// Each edge is set up, takes three passes of the shared 17x17 multiplier,
// then goes through the two-bit-per-cycle square root, and its root is
// added to the perimeter. A last vertex also adds the closing edge and
// then loads the result.
// req_stall is high while a vertex is in progress.
// Reset (synchronous) clears all sums and the count and drops rsp_valid.
// While rsp_stall holds a result, new vertices are still taken; only the
// loading of the next result waits until the pending one is transferred.
// ----------------------------------------------------------------------------
module polygon_area_perimeter_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [pap_pkg::COORD_W-1:0]  req_x_coord,
   input  logic signed [pap_pkg::COORD_W-1:0]  req_y_coord,
   input  logic                                req_last_vertex,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [pap_pkg::AREA_OUT_W-1:0]      rsp_area_doubled,
   output logic [pap_pkg::PERIM_W-1:0]         rsp_perimeter_q8,
   output logic [pap_pkg::TOTAL_W-1:0]         rsp_vertex_total,
   output logic                                rsp_overflow
);
   import pap_pkg::*;

   pap_cmd_type  cmd;
   pap_stat_type stat;

   pap_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_last_vertex (req_last_vertex),
      .stat            (stat),
      .cmd             (cmd)
   );

   pap_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_x_coord      (req_x_coord),
      .req_y_coord      (req_y_coord),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_area_doubled (rsp_area_doubled),
      .rsp_perimeter_q8 (rsp_perimeter_q8),
      .rsp_vertex_total (rsp_vertex_total),
      .rsp_overflow     (rsp_overflow)
   );

endmodule

// File: bench/polygon_summary_checker.sv
// ----------------------------------------------------------------------------
// polygon_summary_checker
// Watches the vertex and result channels of the polygon area and perimeter
// block, works out each polygon's summary from the accepted vertices and
// compares it, field by field, with the result the block returns.
// ----------------------------------------------------------------------------
module polygon_summary_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic signed [pap_pkg::COORD_W-1:0]  req_x_coord,
   input  logic signed [pap_pkg::COORD_W-1:0]  req_y_coord,
   input  logic                                req_last_vertex,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic [pap_pkg::AREA_OUT_W-1:0]      rsp_area_doubled,
   input  logic [pap_pkg::PERIM_W-1:0]         rsp_perimeter_q8,
   input  logic [pap_pkg::TOTAL_W-1:0]         rsp_vertex_total,
   input  logic                                rsp_overflow,
   output int                                  failures,
   output int                                  pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import pap_pkg::*;

   localparam longint AREA_CEIL = (64'sd1 <<< (AREA_W - 1)) - 1;
   localparam longint AREA_FLOOR = -AREA_CEIL - 1;
   localparam longint unsigned PERIM_CEIL = (64'd1 << PERIM_W) - 1;
   localparam longint unsigned AREA_OUT_CEIL = (64'd1 << AREA_OUT_W) - 1;

   typedef struct packed {
      logic [AREA_OUT_W-1:0] area_doubled;
      logic [PERIM_W-1:0]    perimeter_q8;
      logic [TOTAL_W-1:0]    vertex_total;
      logic                  overflow;
   } polygon_summary_type;

   polygon_summary_type expected_summaries [$];

   logic signed [COORD_W-1:0] first_x, first_y, prev_x, prev_y;
   longint                    area_sum;
   longint unsigned           perim_sum;
   int                        vertex_count;
   logic                      over_limit;
   int                        mismatches = 0;

   function automatic void start_polygon();
      first_x = '0;
      first_y = '0;
      prev_x = '0;
      prev_y = '0;
      area_sum = 0;
      perim_sum = 0;
      vertex_count = 0;
      over_limit = 1'b0;
   endfunction

   // floor(sqrt(dx^2 + dy^2) * 256), bit by bit
   function automatic longint unsigned edge_length_q8(
      input logic signed [COORD_W-1:0] ax,
      input logic signed [COORD_W-1:0] ay,
      input logic signed [COORD_W-1:0] bx,
      input logic signed [COORD_W-1:0] by
   );
      longint          dx, dy;
      longint unsigned radicand, root, trial;
      dx = longint'(ax) - longint'(bx);
      dy = longint'(ay) - longint'(by);
      radicand = longint'(dx * dx + dy * dy) << FRAC_SHIFT;
      root = 0;
      for (int b = 26; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= radicand)
            root = trial;
      end
      return root;
   endfunction

   function automatic void fold_edge(
      input logic signed [COORD_W-1:0] ax,
      input logic signed [COORD_W-1:0] ay,
      input logic signed [COORD_W-1:0] bx,
      input logic signed [COORD_W-1:0] by
   );
      longint total;
      total = area_sum + (longint'(ax) - longint'(bx)) * (longint'(by) + longint'(ay));
      if (total > AREA_CEIL)
         total = AREA_CEIL;
      if (total < AREA_FLOOR)
         total = AREA_FLOOR;
      area_sum = total;
      perim_sum = perim_sum + edge_length_q8(ax, ay, bx, by);
      if (perim_sum > PERIM_CEIL)
         perim_sum = PERIM_CEIL;
   endfunction

   function automatic void absorb_vertex(
      input logic signed [COORD_W-1:0] x,
      input logic signed [COORD_W-1:0] y,
      input logic                      last
   );
      polygon_summary_type summary;
      longint unsigned     magnitude;
      if (vertex_count == 0) begin
         first_x = x;
         first_y = y;
         vertex_count = 1;
      end else begin
         fold_edge(prev_x, prev_y, x, y);
         if (vertex_count >= MAX_VERTICES)
            over_limit = 1'b1;
         else
            vertex_count++;
      end
      prev_x = x;
      prev_y = y;
      if (last) begin
         // closing edge back to the first vertex
         fold_edge(prev_x, prev_y, first_x, first_y);
         magnitude = (area_sum < 0) ? -area_sum : area_sum;
         if (magnitude > AREA_OUT_CEIL)
            magnitude = AREA_OUT_CEIL;
         summary.area_doubled = magnitude[AREA_OUT_W-1:0];
         summary.perimeter_q8 = perim_sum[PERIM_W-1:0];
         summary.vertex_total = vertex_count[TOTAL_W-1:0];
         summary.overflow = over_limit;
         expected_summaries.push_back(summary);
         start_polygon();
      end
   endfunction

   function automatic void check_field(
      input string       field,
      input logic [63:0] want,
      input logic [63:0] got
   );
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      polygon_summary_type want;
      if (reset) begin
         start_polygon();
      end else begin
         if (req_valid && !req_stall)
            absorb_vertex(req_x_coord, req_y_coord, req_last_vertex);
         if (rsp_valid && !rsp_stall) begin
            if (expected_summaries.size() == 0) begin
               $error("result transfer with no polygon closed: area_doubled %0d",
                      rsp_area_doubled);
               mismatches++;
            end else begin
               want = expected_summaries.pop_front();
               check_field("area_doubled", 64'(want.area_doubled), 64'(rsp_area_doubled));
               check_field("perimeter_q8", 64'(want.perimeter_q8), 64'(rsp_perimeter_q8));
               check_field("vertex_total", 64'(want.vertex_total), 64'(rsp_vertex_total));
               check_field("overflow", 64'(want.overflow), 64'(rsp_overflow));
            end
         end
      end
      pending <= expected_summaries.size();
      failures <= mismatches;
   end

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the polygon area and perimeter block.
// Feeds directed polygons (extreme corners, both windings, one and two
// vertices, degenerate shapes), then random polygons with random idling on
// both channels and one long result hold-off, then a short stretch of
// random polygons with no idling.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pap_pkg::*;

   localparam int RANDOM_ITEMS   = 680;
   localparam int QUIET_ITEMS    = 80;
   localparam int LONG_HOLD      = 400;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 100;

   typedef enum int {
      SPREAD_FULL,
      SPREAD_NEAR,
      SPREAD_EXTREME
   } coord_style_type;

   localparam logic signed [COORD_W-1:0] EXTREME_VALUES [6] = '{
      16'sh8000, 16'sh8001, 16'shFFFF, 16'sh0000, 16'sh0001, 16'sh7FFF
   };

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic signed [COORD_W-1:0] req_x_coord;
   logic signed [COORD_W-1:0] req_y_coord;
   logic                      req_last_vertex;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [AREA_OUT_W-1:0]     rsp_area_doubled;
   logic [PERIM_W-1:0]        rsp_perimeter_q8;
   logic [TOTAL_W-1:0]        rsp_vertex_total;
   logic                      rsp_overflow;

   int   failures;
   int   pending;
   int   idle_cycles = 0;
   logic random_phase;
   logic quiet;
   int   pause_odds;

   polygon_area_perimeter_top uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_x_coord      (req_x_coord),
      .req_y_coord      (req_y_coord),
      .req_last_vertex  (req_last_vertex),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_area_doubled (rsp_area_doubled),
      .rsp_perimeter_q8 (rsp_perimeter_q8),
      .rsp_vertex_total (rsp_vertex_total),
      .rsp_overflow     (rsp_overflow)
   );

   polygon_summary_checker summary_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_x_coord      (req_x_coord),
      .req_y_coord      (req_y_coord),
      .req_last_vertex  (req_last_vertex),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_area_doubled (rsp_area_doubled),
      .rsp_perimeter_q8 (rsp_perimeter_q8),
      .rsp_vertex_total (rsp_vertex_total),
      .rsp_overflow     (rsp_overflow),
      .failures         (failures),
      .pending          (pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // result side: random stall bursts, one long hold-off, none at the end
   initial begin
      bit backlog_done;
      backlog_done = 1'b0;
      rsp_stall <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if (quiet) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else if (random_phase && !backlog_done) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            backlog_done = 1'b1;
         end else if ($urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
      end
   end

   task automatic put_vertex(
      input logic signed [COORD_W-1:0] x,
      input logic signed [COORD_W-1:0] y,
      input logic                      last
   );
      if (!quiet && $urandom_range(0, 3) < pause_odds) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_x_coord <= x;
      req_y_coord <= y;
      req_last_vertex <= last;
      do @(posedge clock); while (req_stall);
   endtask

   function automatic logic signed [COORD_W-1:0] pick_coord(input coord_style_type style);
      case (style)
         SPREAD_NEAR:    return COORD_W'(int'($urandom_range(0, 16)) - 8);
         SPREAD_EXTREME: return EXTREME_VALUES[$urandom_range(0, 5)];
         default:        return COORD_W'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic random_polygon(input int vertices, input coord_style_type style);
      for (int i = 0; i < vertices; i++)
         put_vertex(pick_coord(style), pick_coord(style), i == vertices - 1);
   endtask

   initial begin
      int random_items;
      int vertices;
      int roll;
      random_phase <= 1'b0;
      quiet <= 1'b0;
      pause_odds = 1;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_x_coord <= '0;
      req_y_coord <= '0;
      req_last_vertex <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single vertex closes onto itself
      put_vertex(16'sh7FFF, 16'sh8000, 1'b1);
      put_vertex(16'sh0000, 16'sh0000, 1'b1);
      // two vertices: edge out and back
      put_vertex(16'sh8000, 16'sh8000, 1'b0);
      put_vertex(16'sh7FFF, 16'sh7FFF, 1'b1);
      // full-range square, counterclockwise then clockwise
      put_vertex(16'sh8000, 16'sh8000, 1'b0);
      put_vertex(16'sh7FFF, 16'sh8000, 1'b0);
      put_vertex(16'sh7FFF, 16'sh7FFF, 1'b0);
      put_vertex(16'sh8000, 16'sh7FFF, 1'b1);
      put_vertex(16'sh8000, 16'sh8000, 1'b0);
      put_vertex(16'sh8000, 16'sh7FFF, 1'b0);
      put_vertex(16'sh7FFF, 16'sh7FFF, 1'b0);
      put_vertex(16'sh7FFF, 16'sh8000, 1'b1);
      // 3-4-5 triangle with exact edge lengths
      put_vertex(16'sd0, 16'sd0, 1'b0);
      put_vertex(16'sd3, 16'sd0, 1'b0);
      put_vertex(16'sd0, 16'sd4, 1'b1);
      // repeated vertex, zero-length edges
      put_vertex(16'sd5, -16'sd5, 1'b0);
      put_vertex(16'sd5, -16'sd5, 1'b0);
      put_vertex(16'sd5, -16'sd5, 1'b1);

      random_phase <= 1'b1;
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         roll = $urandom_range(0, 19);
         if (roll < 16)
            vertices = $urandom_range(1, 6);
         else if (roll < 19)
            vertices = $urandom_range(7, 30);
         else
            vertices = $urandom_range(31, 80);
         pause_odds = $urandom_range(0, 3);
         random_polygon(vertices, coord_style_type'($urandom_range(0, 2)));
         random_items += vertices;
      end

      // closing stretch with no idling on either side
      quiet <= 1'b1;
      pause_odds = 0;
      random_items = 0;
      while (random_items < QUIET_ITEMS) begin
         vertices = $urandom_range(1, 6);
         random_polygon(vertices, coord_style_type'($urandom_range(0, 2)));
         random_items += vertices;
      end
      req_valid <= 1'b0;

      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
